[hdl/spid_pkg.sv]
// spid_pkg: shared types, widths and constants of the speed PID block.
// No dependencies; every other file of the block refers to it by scoped names.
package spid_pkg;

  localparam int GAIN_FRAC_BITS = 12;
  localparam int INTEGRAL_WIDTH = 32;

  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int DERR_W  = ERR_W + 1;
  localparam int TP_W    = GAIN_W + 1 + ERR_W;
  localparam int TD_W    = GAIN_W + 1 + DERR_W;
  localparam int TI_W    = GAIN_W + 1 + INTEGRAL_WIDTH;
  localparam int SUM_W   = INTEGRAL_WIDTH + 19;

  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd7660;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd279;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd4874;
  localparam logic [GAIN_W-1:0] SEP_LIMIT_RST = 16'd300;

  typedef logic signed [SPEED_W-1:0] speed_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 2'd0,
    REG_GAIN_I    = 2'd1,
    REG_GAIN_D    = 2'd2,
    REG_SEP_LIMIT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] sep_limit;
  } cfg_t;

  // error stage -> multiply stage
  typedef struct packed {
    logic                             valid;
    logic signed [ERR_W-1:0]          err;
    logic signed [DERR_W-1:0]         derr;
    logic signed [INTEGRAL_WIDTH-1:0] integ;
  } err_pkt_t;

  // multiply stage -> output stage
  typedef struct packed {
    logic                   valid;
    logic signed [TP_W-1:0] tp;
    logic signed [TI_W-1:0] ti;
    logic signed [TD_W-1:0] td;
  } prod_pkt_t;

endpackage

[hdl/spid_if.sv]
// spid_in_if / spid_out_if: valid/ready channels for speed samples and drive values.
// Depends on spid_pkg for the field type.
interface spid_in_if;
  logic            valid;
  logic            ready;
  spid_pkg::speed_t target_speed;
  spid_pkg::speed_t measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface spid_out_if;
  logic            valid;
  logic            ready;
  spid_pkg::speed_t drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

[hdl/spid_cfg_regs.sv]
// spid_cfg_regs: gain and separation-limit registers behind the write port.
// Depends on spid_pkg.
module spid_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [spid_pkg::GAIN_W-1:0]         cfg_wdata_i,
  output spid_pkg::cfg_t                      cfg_o
);

  spid_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (spid_pkg::cfg_reg_e'(cfg_idx_i))
        spid_pkg::REG_GAIN_P:    cfg_d.gain_p    = cfg_wdata_i;
        spid_pkg::REG_GAIN_I:    cfg_d.gain_i    = cfg_wdata_i;
        spid_pkg::REG_GAIN_D:    cfg_d.gain_d    = cfg_wdata_i;
        spid_pkg::REG_SEP_LIMIT: cfg_d.sep_limit = cfg_wdata_i;
        default:                 cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= spid_pkg::GAIN_P_RST;
      cfg_q.gain_i    <= spid_pkg::GAIN_I_RST;
      cfg_q.gain_d    <= spid_pkg::GAIN_D_RST;
      cfg_q.sep_limit <= spid_pkg::SEP_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/spid_err_stage.sv]
// spid_err_stage: input register, error, integral separation and the kept state.
// Depends on spid_pkg.
module spid_err_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  spid_pkg::speed_t            target_speed_i,
  input  spid_pkg::speed_t            measured_speed_i,
  input  logic [spid_pkg::GAIN_W-1:0] sep_limit_i,
  output spid_pkg::err_pkt_t          pkt_o
);

  localparam int IW  = spid_pkg::INTEGRAL_WIDTH;
  localparam int EW  = spid_pkg::ERR_W;

  logic                    a_valid_q;
  spid_pkg::speed_t        tgt_q, meas_q;
  logic signed [IW-1:0]    integ_q, integ_d;
  logic signed [EW-1:0]    prev_q;
  spid_pkg::err_pkt_t      pkt_q, pkt_d;

  logic signed [EW-1:0]    err;
  logic [EW-1:0]           mag;
  logic signed [IW:0]      acc_sum;
  logic                    advance;

  assign advance = en_i && a_valid_q;

  always_comb begin
    err     = EW'(tgt_q) - EW'(meas_q);
    mag     = err[EW-1] ? EW'(-err) : EW'(err);
    acc_sum = (IW+1)'(integ_q) + (IW+1)'(err);
    integ_d = integ_q;
    if (mag <= EW'(sep_limit_i)) begin
      // saturate on signed overflow of the extended sum
      if (acc_sum[IW] != acc_sum[IW-1]) begin
        integ_d = acc_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      end else begin
        integ_d = acc_sum[IW-1:0];
      end
    end
    pkt_d.valid = a_valid_q;
    pkt_d.err   = err;
    pkt_d.derr  = spid_pkg::DERR_W'(err) - spid_pkg::DERR_W'(prev_q);
    pkt_d.integ = integ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      pkt_q     <= '0;
      integ_q   <= '0;
      prev_q    <= '0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      pkt_q     <= pkt_d;
      if (advance) begin
        integ_q <= integ_d;
        prev_q  <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tgt_q  <= target_speed_i;
      meas_q <= measured_speed_i;
    end
  end

  assign pkt_o = pkt_q;

  // state only moves when an item leaves the input register
  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(integ_q) && $stable(prev_q))
    else $error("integral or previous error changed without an item");

  a_prev_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> prev_q == $past(err))
    else $error("previous error not taken from the processed item");

  a_pkt_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> pkt_q.valid && pkt_q.integ == integ_q)
    else $error("forwarded integral differs from kept integral");

endmodule

[hdl/spid_mult_stage.sv]
// spid_mult_stage: the three gain products, registered.
// Depends on spid_pkg.
module spid_mult_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  spid_pkg::cfg_t      cfg_i,
  input  spid_pkg::err_pkt_t  pkt_i,
  output spid_pkg::prod_pkt_t pkt_o
);

  spid_pkg::prod_pkt_t pkt_q, pkt_d;

  always_comb begin
    pkt_d.valid = pkt_i.valid;
    pkt_d.tp    = $signed({1'b0, cfg_i.gain_p}) * pkt_i.err;
    pkt_d.ti    = $signed({1'b0, cfg_i.gain_i}) * pkt_i.integ;
    pkt_d.td    = $signed({1'b0, cfg_i.gain_d}) * pkt_i.derr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else if (en_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

[hdl/spid_out_stage.sv]
// spid_out_stage: sum, scale toward zero, clamp to 16 bits; output register.
// Depends on spid_pkg.
module spid_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  spid_pkg::prod_pkt_t pkt_i,
  output logic                valid_o,
  output spid_pkg::speed_t    drive_o
);

  localparam int SW = spid_pkg::SUM_W;
  localparam logic [SW-1:0]        RND     = SW'((64'd1 << spid_pkg::GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [SW-1:0] OUT_MAX = SW'(32767);
  localparam logic signed [SW-1:0] OUT_MIN = -SW'(32768);

  logic signed [SW-1:0] sum, adj, quo;
  spid_pkg::speed_t     drive_d, drive_q;
  logic                 valid_q;

  always_comb begin
    sum = SW'(pkt_i.tp) + SW'(pkt_i.ti) + SW'(pkt_i.td);
    // bias negatives so the arithmetic shift truncates toward zero
    adj = sum + (sum[SW-1] ? $signed(RND) : $signed(SW'(0)));
    quo = adj >>> spid_pkg::GAIN_FRAC_BITS;
    if (quo > OUT_MAX) begin
      drive_d = OUT_MAX[spid_pkg::SPEED_W-1:0];
    end else if (quo < OUT_MIN) begin
      drive_d = OUT_MIN[spid_pkg::SPEED_W-1:0];
    end else begin
      drive_d = quo[spid_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= pkt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q <= drive_d;
    end
  end

  assign valid_o = valid_q;
  assign drive_o = drive_q;

endmodule

[hdl/speed_pid_integral_separation.sv]
// Positional PID speed controller with integral separation. Each input item
// (target_speed, measured_speed) gives exactly one drive_value item, in order.
// The error target - measured is added to a saturating 32-bit integral only
// when |error| <= separation_limit; the output is
// (gain_p*err + gain_i*integral + gain_d*(err - previous err)) / 4096, truncated
// toward zero and clamped to signed 16 bits. Gains are unsigned Q4.12.
// Rate: one item per clock unless the output stalls; each item passes through the
// input register, then the error/integral stage, multiplier stage and output
// register. The pipeline stalls only while the output register holds an
// item that the sink has not taken. Write configuration only while idle.
// Depends on spid_pkg, spid_if, spid_cfg_regs and the three stage modules.
module speed_pid_integral_separation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spid_pkg::GAIN_W-1:0]     cfg_wdata_i,
  spid_in_if.sink                         in_i,
  spid_out_if.source                      out_o
);

  spid_pkg::cfg_t      cfg;
  spid_pkg::err_pkt_t  err_pkt;
  spid_pkg::prod_pkt_t prod_pkt;
  logic                out_valid;
  logic                pipe_en;

  // whole pipeline advances unless a finished item sits unclaimed at the output
  assign pipe_en  = !out_valid || out_o.ready;
  assign in_i.ready = pipe_en;

  spid_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  spid_err_stage u_err (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (pipe_en),
    .valid_i         (in_i.valid),
    .target_speed_i  (in_i.target_speed),
    .measured_speed_i(in_i.measured_speed),
    .sep_limit_i     (cfg.sep_limit),
    .pkt_o           (err_pkt)
  );

  spid_mult_stage u_mult (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (pipe_en),
    .cfg_i (cfg),
    .pkt_i (err_pkt),
    .pkt_o (prod_pkt)
  );

  spid_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .pkt_i  (prod_pkt),
    .valid_o(out_valid),
    .drive_o(out_o.drive_value)
  );

  assign out_o.valid = out_valid;

  // input is refused only while the output register is full and stalled
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid && !out_o.ready)
    else $error("input refused without an output stall");

  // a stalled result is not lost from the output register
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.ready |=> out_valid && $stable(out_o.drive_value))
    else $error("stalled drive value dropped or changed");

endmodule

[bench/spid_checker.sv]
`timescale 1ns / 100ps
// spid_checker: tracks the gain and limit writes, predicts the drive value of
// every accepted speed item and compares it with the output channel.
// Depends on spid_pkg and on the channel interfaces of spid_if.
module spid_checker
  import spid_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_wdata_i,
  spid_in_if                   in_mon,
  spid_out_if                  out_mon,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint INTEG_MAX = (longint'(1) << (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint TI_LIMIT  = longint'(1) << 40;

  cfg_t                             cfg_q;
  logic signed [INTEGRAL_WIDTH-1:0] integral_q;
  logic signed [ERR_W-1:0]          prev_err_q;
  speed_t                           drive_exp_q [$];

  // One controller step: updates the integral and previous error, returns the drive.
  function automatic speed_t pid_drive_step(speed_t tgt, speed_t meas);
    longint e;
    longint acc;
    longint tp;
    longint ti;
    longint td;
    longint q;
    e = longint'(tgt) - longint'(meas);
    if ((e < 0 ? -e : e) <= longint'(cfg_q.sep_limit)) begin
      acc = longint'(integral_q) + e;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      else if (acc < INTEG_MIN) acc = INTEG_MIN;
      integral_q = acc[INTEGRAL_WIDTH-1:0];
    end
    tp = longint'(cfg_q.gain_p) * e;
    ti = longint'(cfg_q.gain_i) * longint'(integral_q);
    if (ti > TI_LIMIT) ti = TI_LIMIT;
    else if (ti < -TI_LIMIT) ti = -TI_LIMIT;
    td = longint'(cfg_q.gain_d) * (e - longint'(prev_err_q));
    // longint division truncates toward zero
    q = (tp + ti + td) / (longint'(1) << GAIN_FRAC_BITS);
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    prev_err_q = e[ERR_W-1:0];
    return speed_t'(q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    speed_t drive_want;
    if (!rst_ni) begin
      cfg_q.gain_p    = GAIN_P_RST;
      cfg_q.gain_i    = GAIN_I_RST;
      cfg_q.gain_d    = GAIN_D_RST;
      cfg_q.sep_limit = SEP_LIMIT_RST;
      integral_q      = '0;
      prev_err_q      = '0;
      drive_exp_q.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_GAIN_P:    cfg_q.gain_p    = cfg_wdata_i;
          REG_GAIN_I:    cfg_q.gain_i    = cfg_wdata_i;
          REG_GAIN_D:    cfg_q.gain_d    = cfg_wdata_i;
          REG_SEP_LIMIT: cfg_q.sep_limit = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        drive_exp_q.push_back(pid_drive_step(in_mon.target_speed, in_mon.measured_speed));
      if (out_mon.valid && out_mon.ready) begin
        if (drive_exp_q.size() == 0) begin
          $error("drive_value: expected none, actual %0d", out_mon.drive_value);
          fail_count_o++;
        end else begin
          drive_want = drive_exp_q.pop_front();
          if (out_mon.drive_value !== drive_want) begin
            $error("drive_value: expected %0d, actual %0d", drive_want, out_mon.drive_value);
            fail_count_o++;
          end
        end
      end
      pending_o = drive_exp_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for speed_pid_integral_separation.
// Depends on spid_pkg, spid_if, the block itself and spid_checker.
module tb_top;
  import spid_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [GAIN_W-1:0]   cfg_wdata;
  int                  fail_count;
  int                  pending;

  spid_in_if  in_ch ();
  spid_out_if out_ch ();

  speed_pid_integral_separation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  spid_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Directed items run with the reset gains. They cover zero error, errors
  // exactly at and one past the separation limit on both signs, the extreme
  // errors (+-65535) and the largest error step between items.
  localparam int N_DIR = 18;
  localparam speed_t DIR_TGT [N_DIR] = '{
    16'sd0, 16'sd100, 16'sd100, 16'sd0, 16'sd300, 16'sd301, 16'sd0,
    16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768,
    16'sd1, 16'sd0, -16'sd1, 16'sd12345, -16'sd150, 16'sd0
  };
  localparam speed_t DIR_MEAS [N_DIR] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd300, 16'sd0, 16'sd0, 16'sd301,
    -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0,
    16'sd0, 16'sd1, -16'sd2, 16'sd12000, 16'sd150, 16'sd0
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one item after a random gap (none when no_gap) and waits until it is taken.
  // Valid stays high between back-to-back items.
  task automatic send_item(speed_t tgt, speed_t meas, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.target_speed   <= tgt;
    in_ch.measured_speed <= meas;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until every predicted drive value has come out, plus pipeline slack.
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_gains(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                           logic [GAIN_W-1:0] gd, logic [GAIN_W-1:0] sep);
    drain_pipe();
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_SEP_LIMIT, sep);
  endtask

  // Mostly errors around the separation limit so the integral moves; the
  // rest is full-range noise and rail values.
  task automatic pick_item(int lim, output speed_t tgt, output speed_t meas);
    int m_i;
    int t_i;
    int span;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      span = (lim > 2000 ? 2000 : lim) + 20;
      m_i  = int'($urandom_range(0, 65535)) - 32768;
      t_i  = m_i + int'($urandom_range(0, 2 * span)) - span;
      if (t_i > 32767) t_i = 32767;
      if (t_i < -32768) t_i = -32768;
      tgt  = speed_t'(t_i);
      meas = speed_t'(m_i);
    end else if (mode <= 7) begin
      tgt  = speed_t'($urandom());
      meas = speed_t'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0: tgt = 16'sh7fff;
        1: tgt = 16'sh8000;
        2: tgt = 16'sh0000;
        default: tgt = 16'shffff;
      endcase
      case ($urandom_range(0, 3))
        0: meas = 16'sh7fff;
        1: meas = 16'sh8000;
        2: meas = 16'sh0000;
        default: meas = 16'shffff;
      endcase
    end
  endtask

  task automatic run_random(int lim, int n_items);
    speed_t tgt;
    speed_t meas;
    for (int i = 0; i < n_items; i++) begin
      pick_item(lim, tgt, meas);
      // every 200 items, a burst of 40 with no gaps
      send_item(tgt, meas, (i % 200) < 40);
    end
  endtask

  task automatic run_phase(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                           logic [GAIN_W-1:0] gd, logic [GAIN_W-1:0] sep, int n_items);
    set_gains(gp, gi, gd, sep);
    run_random(int'(sep), n_items);
  endtask

  // Main stimulus
  initial begin
    logic [GAIN_W-1:0] sep;
    in_ch.valid          = 1'b0;
    in_ch.target_speed   = '0;
    in_ch.measured_speed = '0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_GAIN_P;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(DIR_TGT[i], DIR_MEAS[i], 1'b0);

    // Reset gains, then the extremes, then two fixed settings, then random settings.
    run_random(300, 150);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 150);
    run_phase(16'hffff, 16'hffff, 16'hffff, 16'hffff, 250);
    run_phase(16'd7660, 16'd279, 16'd4874, 16'd0, 150);
    run_phase(16'd4096, 16'd0, 16'd0, 16'd300, 100);
    for (int k = 0; k < 4; k++) begin
      sep = (k == 3) ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(0, 1000));
      run_phase(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()), sep, 200);
    end

    // 60 random items with the integral gain at one LSB
    run_phase(16'd7660, 16'd1, 16'd4874, 16'd300, 60);

    drain_pipe();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Sink side: random stalls before each item, stall-free stretches,
  // and two long hold-offs that back the pipeline up into the input.
  initial begin
    int stall;
    int taken;
    out_ch.ready = 1'b0;
    taken        = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 500 || taken == 1200) stall = 80;
      else if ((taken % 300) < 60) stall = 0;
      else stall = $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Watchdog: a few times the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
